// File: hdl/tts_pkg.sv
// Shared types and constants for the tag tracking slot table.
// Used by tts_eval and the top level; depends on nothing.
`default_nettype none

package tts_pkg;

  // Default sizing, handed to the top level as parameter defaults.
  localparam int TAG_COUNT_DEF     = 32;
  localparam int SLOTS_PER_TAG_DEF = 4;

  // Fixed field widths of the transaction payloads.
  localparam int COORD_BITS = 12;
  localparam int TAG_BITS   = 5;
  localparam int IDX_BITS   = 2;
  localparam int TIME_BITS  = 32;
  localparam int MATCH_BITS = 13;

  // Configuration port.
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 32;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MATCH_DISTANCE = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LIVE_TIME      = 2'd1;

  // Register values after reset.
  localparam logic [MATCH_BITS-1:0] MATCH_DISTANCE_RST = 13'd100;
  localparam logic [TIME_BITS-1:0]  LIVE_TIME_RST      = 32'd1000000;

  // Command codes.
  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  typedef struct packed {
    logic                  cmd;
    logic [TAG_BITS-1:0]   tag_id;
    logic                  detection_good;
    logic [COORD_BITS-1:0] center_x;
    logic [COORD_BITS-1:0] center_y;
    logic [TIME_BITS-1:0]  now_time;
  } tts_in_t;

  typedef struct packed {
    logic                  found;
    logic [IDX_BITS-1:0]   slot_index;
    logic [COORD_BITS-1:0] slot_x;
    logic [COORD_BITS-1:0] slot_y;
    logic [TIME_BITS-1:0]  seen_time;
    logic [TIME_BITS-1:0]  seen_gap;
    logic                  last;
  } tts_out_t;

  // One stored slot.
  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [TIME_BITS-1:0]  seen;
    logic [TIME_BITS-1:0]  gap;
  } tts_entry_t;

  // Verdict of the slot evaluation unit.
  typedef struct packed {
    logic near;   // Manhattan distance within the threshold
    logic stale;  // last sighting not after the alive limit
    logic live;   // last sighting not before the alive limit
  } tts_eval_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_FLUSH
  } tts_state_t;

endpackage

`default_nettype wire

// File: hdl/tts_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; no package dependency.
`default_nettype none

module tts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: hdl/tts_eval.sv
// Slot evaluation unit: distance and age tests for one stored slot per cycle.
// Depends on tts_pkg for the slot entry and verdict types.
`default_nettype none

module tts_eval (
  input  wire logic [tts_pkg::COORD_BITS-1:0] cx,
  input  wire logic [tts_pkg::COORD_BITS-1:0] cy,
  input  wire logic [tts_pkg::MATCH_BITS-1:0] match_distance,
  input  wire logic [tts_pkg::TIME_BITS-1:0]  limit,
  input  wire tts_pkg::tts_entry_t            entry,
  output tts_pkg::tts_eval_t                  verdict
);

  localparam int DW = tts_pkg::COORD_BITS + 1;

  logic [tts_pkg::COORD_BITS-1:0] dx;
  logic [tts_pkg::COORD_BITS-1:0] dy;
  logic [DW-1:0]                  span;

  // Absolute differences per axis, then their sum.
  always_comb begin
    dx   = (cx > entry.x) ? (cx - entry.x) : (entry.x - cx);
    dy   = (cy > entry.y) ? (cy - entry.y) : (entry.y - cy);
    span = DW'(dx) + DW'(dy);
  end

  // Compare the distance with the threshold and the sighting with the limit.
  always_comb begin
    verdict.near  = (32'(span) <= 32'(match_distance));
    verdict.stale = (entry.seen <= limit);
    verdict.live  = (entry.seen >= limit);
  end

endmodule

`default_nettype wire

// File: hdl/tag_track_slot_table_unit.sv
// Top level of the tag tracking slot table: sequencer, slot store and outputs.
// Depends on tts_pkg, tts_ram and tts_eval.
//
// Usage. A transaction is taken when start is high and busy is low. An update
// (cmd 0) with a good detection for a tag in range scans the slots of that tag
// in order and writes the detection into the first slot that is stale or
// whose centre lies within match_distance; otherwise it is dropped. A query
// (cmd 1) reports each live slot of the tag as one result, in slot order, with
// last set on the final one, or a single not-found result.
// Each result is shown on out_data for one cycle with out_strobe high; the
// receiver cannot hold results off, and none is needed since results leave at
// most one per cycle.
// Sequence: each slot is handled as a RAM read and then an evaluation in the
// shared distance and age unit. An update returns to idle after the slot it
// writes or after the last slot, and a dropped one never leaves idle; a query
// ends in a flush state, which it enters at once for a tag out of range.
// Configuration writes are taken whenever the block is idle (cfg_ready high).
// Reset restores the register defaults and clears one valid flag per slot, so
// the whole table reads as zero at once; no clearing pass is needed.
`default_nettype none

module tag_track_slot_table_unit #(
  parameter int TAG_COUNT     = tts_pkg::TAG_COUNT_DEF,
  parameter int SLOTS_PER_TAG = tts_pkg::SLOTS_PER_TAG_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // Command channel.
  input  wire logic                               start,
  output logic                                    busy,
  input  wire tts_pkg::tts_in_t                   in_data,
  // Result channel.
  output logic                                    out_strobe,
  output tts_pkg::tts_out_t                       out_data,
  // Configuration channel.
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [tts_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  wire logic [tts_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int DEPTH = TAG_COUNT * SLOTS_PER_TAG;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int JW    = (SLOTS_PER_TAG > 1) ? $clog2(SLOTS_PER_TAG) : 1;
  localparam int EW    = $bits(tts_pkg::tts_entry_t);

  tts_pkg::tts_state_t state_r, state_nxt;

  // Transaction context.
  logic                                cmd_r;
  logic [tts_pkg::COORD_BITS-1:0]      cx_r;
  logic [tts_pkg::COORD_BITS-1:0]      cy_r;
  logic [tts_pkg::TIME_BITS-1:0]       now_r;
  logic [tts_pkg::TIME_BITS-1:0]       lim_r;
  logic [AW-1:0]                       base_r;
  logic [JW-1:0]                       j_r;

  // Configuration registers.
  logic [tts_pkg::MATCH_BITS-1:0]      md_r;
  logic [tts_pkg::TIME_BITS-1:0]       live_r;

  // Slot store.
  logic [DEPTH-1:0]                    vld_r;
  logic                                rd_vld_r;
  logic [EW-1:0]                       ram_rdata;
  logic                                ram_re;
  logic                                ram_we;
  logic [AW-1:0]                       addr;
  tts_pkg::tts_entry_t                 entry_q;
  tts_pkg::tts_entry_t                 entry_w;
  tts_pkg::tts_eval_t                  verdict;

  // Held result and output register.
  logic                                pend_vld_r;
  tts_pkg::tts_out_t                   pend_r;
  logic                                out_strobe_r;
  tts_pkg::tts_out_t                   out_r;

  logic                                accept;
  logic                                tag_oor;
  logic                                last_slot;
  logic                                hit;
  logic                                emit;
  tts_pkg::tts_out_t                   emit_data;
  logic [tts_pkg::TIME_BITS-1:0]       lim_in;

  assign busy       = (state_r != tts_pkg::ST_IDLE);
  assign cfg_ready  = (state_r == tts_pkg::ST_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_data   = out_r;

  assign accept    = start && !busy;
  assign tag_oor   = (32'(in_data.tag_id) >= 32'(TAG_COUNT));
  assign last_slot = (j_r == JW'(SLOTS_PER_TAG - 1));
  assign addr      = base_r + AW'(j_r);
  assign hit       = verdict.near || verdict.stale;

  // Alive limit for the incoming transaction, saturated at zero.
  assign lim_in = (in_data.now_time > live_r) ? (in_data.now_time - live_r) : '0;

  // Slots never written read as zero.
  assign entry_q = rd_vld_r ? tts_pkg::tts_entry_t'(ram_rdata) : '0;

  // Replacement entry for an update.
  always_comb begin
    entry_w.x    = cx_r;
    entry_w.y    = cy_r;
    entry_w.seen = now_r;
    entry_w.gap  = now_r - entry_q.seen;
  end

  tts_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr),
    .wdata (EW'(entry_w)),
    .re    (ram_re),
    .raddr (addr),
    .rdata (ram_rdata)
  );

  tts_eval u_eval (
    .cx             (cx_r),
    .cy             (cy_r),
    .match_distance (md_r),
    .limit          (lim_r),
    .entry          (entry_q),
    .verdict        (verdict)
  );

  // Next-state logic of the sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tts_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_data.cmd == tts_pkg::CMD_QUERY) begin
            state_nxt = tag_oor ? tts_pkg::ST_FLUSH : tts_pkg::ST_READ;
          end else if (in_data.detection_good && !tag_oor) begin
            state_nxt = tts_pkg::ST_READ;
          end
        end
      end
      tts_pkg::ST_READ: begin
        state_nxt = tts_pkg::ST_EVAL;
      end
      tts_pkg::ST_EVAL: begin
        if (cmd_r == tts_pkg::CMD_UPDATE) begin
          state_nxt = (hit || last_slot) ? tts_pkg::ST_IDLE : tts_pkg::ST_READ;
        end else begin
          state_nxt = last_slot ? tts_pkg::ST_FLUSH : tts_pkg::ST_READ;
        end
      end
      tts_pkg::ST_FLUSH: begin
        state_nxt = tts_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = tts_pkg::ST_IDLE;
      end
    endcase
  end

  // Output logic of the sequencer: RAM strobes and result emission.
  always_comb begin
    ram_re    = 1'b0;
    ram_we    = 1'b0;
    emit      = 1'b0;
    emit_data = pend_r;
    case (state_r)
      tts_pkg::ST_READ: begin
        ram_re = 1'b1;
      end
      tts_pkg::ST_EVAL: begin
        if (cmd_r == tts_pkg::CMD_UPDATE) begin
          ram_we = hit;
        end else if (verdict.live && pend_vld_r) begin
          // A later live slot exists, so the held one is not the last.
          emit           = 1'b1;
          emit_data.last = 1'b0;
        end
      end
      tts_pkg::ST_FLUSH: begin
        emit = 1'b1;
        if (pend_vld_r) begin
          emit_data.last = 1'b1;
        end else begin
          emit_data      = '0;
          emit_data.last = 1'b1;
        end
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tts_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      md_r   <= tts_pkg::MATCH_DISTANCE_RST;
      live_r <= tts_pkg::LIVE_TIME_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == tts_pkg::CFG_MATCH_DISTANCE) begin
        md_r <= cfg_data[tts_pkg::MATCH_BITS-1:0];
      end else if (cfg_index == tts_pkg::CFG_LIVE_TIME) begin
        live_r <= cfg_data[tts_pkg::TIME_BITS-1:0];
      end
    end
  end

  // Transaction context, captured on acceptance.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r  <= in_data.cmd;
      cx_r   <= in_data.center_x;
      cy_r   <= in_data.center_y;
      now_r  <= in_data.now_time;
      lim_r  <= lim_in;
      base_r <= AW'(in_data.tag_id) * AW'(SLOTS_PER_TAG);
    end
  end

  // Slot counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      j_r <= '0;
    end else if (accept) begin
      j_r <= '0;
    end else if (state_r == tts_pkg::ST_EVAL && state_nxt == tts_pkg::ST_READ) begin
      j_r <= j_r + JW'(1);
    end
  end

  // Per-slot valid flags, and the flag that goes with the read data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (ram_we) begin
        vld_r[addr] <= 1'b1;
      end
      if (ram_re) begin
        rd_vld_r <= vld_r[addr];
      end
    end
  end

  // Held query result: the latest live slot seen so far.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_vld_r <= 1'b0;
    end else if (accept) begin
      pend_vld_r <= 1'b0;
    end else if (state_r == tts_pkg::ST_EVAL && cmd_r == tts_pkg::CMD_QUERY
                 && verdict.live) begin
      pend_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == tts_pkg::ST_EVAL && cmd_r == tts_pkg::CMD_QUERY && verdict.live) begin
      pend_r.found      <= 1'b1;
      pend_r.slot_index <= tts_pkg::IDX_BITS'(j_r);
      pend_r.slot_x     <= entry_q.x;
      pend_r.slot_y     <= entry_q.y;
      pend_r.seen_time  <= entry_q.seen;
      pend_r.seen_gap   <= entry_q.gap;
      pend_r.last       <= 1'b0;
    end
  end

  // Result output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_r <= emit_data;
    end
  end

  // A query always ends with a result marked last.
  a_flush_ends_query: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tts_pkg::ST_FLUSH) |=> (out_strobe && out_data.last))
    else $error("query finished without a last result");

  // Only a found slot may be followed by further results.
  a_not_last_is_found: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_data.last) |-> out_data.found)
    else $error("not-found result without last");

  // Writing a slot completes the update.
  a_write_ends_update: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> (state_r == tts_pkg::ST_IDLE))
    else $error("update continued after a slot write");

  // A result appears only when the previous cycle was an evaluation or flush state.
  a_strobe_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> ($past(state_r) == tts_pkg::ST_FLUSH || $past(state_r) == tts_pkg::ST_EVAL))
    else $error("result strobe without a scan step");

endmodule

`default_nettype wire
